/* design/sql_token_lexer_assert.svh */
// Assertion macros for the SQL token lexer checker
`ifndef SQL_TOKEN_LEXER_ASSERT_SVH
`define SQL_TOKEN_LEXER_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define SLX_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("lexer check failed");
// Next-cycle implication
`define SLX_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("lexer check failed");
`endif

/* design/slx_pkg.sv */
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types and constants of the SQL token lexer.
// ----------------------------------------------------------------------------
`default_nettype none
package slx_pkg;
  localparam int LexMax    = 64;
  localparam int TokenMax  = 256;
  localparam int TextMax   = 65535;
  localparam int OffCapI   = (TextMax < 65535) ? TextMax : 65535;
  localparam logic [15:0] OffCap = 16'(OffCapI);
  localparam logic [5:0]  LexFull = 6'(LexMax - 1);
  localparam logic [8:0]  TokLimit = 9'(TokenMax - 1);
  localparam logic [30:0] Sat31 = 31'h7fffffff;

  localparam logic [5:0] ClInt = 6'd17, ClFloat = 6'd18, ClStr = 6'd19,
    ClIdent = 6'd20, ClStar = 6'd21, ClPlus = 6'd22, ClMinus = 6'd23,
    ClSlash = 6'd24, ClGt = 6'd25, ClLt = 6'd26, ClGte = 6'd27, ClLte = 6'd28,
    ClEq = 6'd29, ClNeq = 6'd30, ClLpar = 6'd31, ClRpar = 6'd32,
    ClComma = 6'd33, ClSemi = 6'd34, ClEof = 6'd35, ClUnk = 6'd36;

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_NUM, M_STR, M_GT, M_LT, M_BANG
  } mode_e;

  typedef struct packed {
    logic [5:0]  cls;
    logic [30:0] ival;
    logic [30:0] whole;
    logic [29:0] frac;
    logic [3:0]  fcnt;
    logic [15:0] start;
    logic [5:0]  len;
    logic        last;
  } tok_t;

  // classified input character
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       space;
    logic       wstart;
    logic       wchar;
    logic       digit;
    logic [7:0] upper;
  } chr_t;

  function automatic logic [5:0] kw_lookup(input logic [55:0] w);
    case (w)
      56'h53454c454354:   kw_lookup = 6'd0;
      56'h46524f4d:       kw_lookup = 6'd1;
      56'h5748455245:     kw_lookup = 6'd2;
      56'h494e53455254:   kw_lookup = 6'd3;
      56'h494e544f:       kw_lookup = 6'd4;
      56'h56414c554553:   kw_lookup = 6'd5;
      56'h435245415445:   kw_lookup = 6'd6;
      56'h5441424c45:     kw_lookup = 6'd7;
      56'h44524f50:       kw_lookup = 6'd8;
      56'h4c495354:       kw_lookup = 6'd9;
      56'h5441424c4553:   kw_lookup = 6'd10;
      56'h414e44:         kw_lookup = 6'd11;
      56'h4f52:           kw_lookup = 6'd12;
      56'h4e4f54:         kw_lookup = 6'd13;
      56'h494e54:         kw_lookup = 6'd14;
      56'h464c4f4154:     kw_lookup = 6'd15;
      56'h535452494e47:   kw_lookup = 6'd16;
      default:            kw_lookup = ClIdent;
    endcase
  endfunction
endpackage
`default_nettype wire

/* design/slx_front.sv */
// ----------------------------------------------------------------------------
// slx_front
// Input stage: accepts characters and classifies them into a small queue.
// ----------------------------------------------------------------------------
`default_nettype none
module slx_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [7:0]    text_char_i,
  input  wire logic          end_of_text_i,
  output slx_pkg::chr_t      chr_o,
  output logic               chr_valid_o,
  input  wire logic          chr_take_i
);
  import slx_pkg::*;
  chr_t q_mem [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  chr_t       c;
  logic       do_push, do_pop;
  logic [7:0] ch;

  assign ch = text_char_i;
  always_comb begin
    c.ch     = ch;
    c.eot    = end_of_text_i;
    c.digit  = ch >= 8'h30 && ch <= 8'h39;
    c.space  = ch == 8'h20 || (ch >= 8'd9 && ch <= 8'd13);
    c.wstart = (ch >= 8'h41 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a) || ch == 8'h5f;
    c.wchar  = c.wstart || c.digit;
    c.upper  = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'd32 : ch;
  end

  assign full_o      = cnt_q == 2'd2;
  assign chr_valid_o = cnt_q != 2'd0;
  assign chr_o       = q_mem[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = chr_take_i && chr_valid_o;
  assign cnt_d       = cnt_q + 2'(do_push) - 2'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wr_q] <= c;
  end
endmodule
`default_nettype wire

/* design/slx_back.sv */
// ----------------------------------------------------------------------------
// slx_back
// Scanner: runs the token state machine, up to two tokens per character.
// ----------------------------------------------------------------------------
`default_nettype none
module slx_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  slx_pkg::chr_t      chr_i,
  input  wire logic          chr_valid_i,
  output logic               chr_take_o,
  output slx_pkg::tok_t      tok_a_o,
  output slx_pkg::tok_t      tok_b_o,
  output logic [1:0]         tok_n_o,
  output logic               tok_we_o,
  input  wire logic [2:0]    space_i
);
  import slx_pkg::*;
  mode_e       mode_q, mode_d;
  logic [5:0]  len_q, len_d;
  logic [15:0] start_q, start_d, off_q, off_d;
  logic [55:0] kw_q, kw_d;
  logic        long_q, long_d;
  logic [30:0] whole_q, whole_d;
  logic [29:0] frac_q, frac_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [1:0]  dots_q, dots_d;
  logic [8:0]  ntok_q, ntok_d;
  tok_t        flt, dsp, two;
  logic        flt_v, dsp_v, two_v, go, use_two;
  logic        absorb, do_flush, do_disp;
  logic [34:0] mul10;
  logic [3:0]  dig;
  logic [15:0] off_p1;
  tok_t        cand [2];
  logic [1:0]  nc, nk;
  chr_t        c;

  assign c = chr_i;
  // need room for two tokens before taking a character
  assign go = chr_valid_i && space_i >= 3'd2;
  assign chr_take_o = go;
  assign dig = c.ch[3:0];
  assign mul10 = {4'd0, whole_q} * 35'd10 + 35'(dig);
  assign off_p1 = (off_q >= OffCap) ? OffCap : off_q + 16'd1;

  function automatic tok_t mk(input logic [5:0] cl, input logic [15:0] st,
                              input logic [5:0] ln);
    tok_t t;
    t = '0;
    t.cls = cl; t.start = st; t.len = ln;
    return t;
  endfunction

  always_comb begin
    flt = mk(ClIdent, start_q, len_q);
    flt_v = 1'b1;
    case (mode_q)
      M_WORD: flt.cls = long_q ? ClIdent : kw_lookup(kw_q);
      M_NUM: begin
        if (dots_q != 2'd0) begin
          flt.cls = ClFloat; flt.whole = whole_q; flt.frac = frac_q; flt.fcnt = fcnt_q;
        end else begin
          flt.cls = ClInt; flt.ival = whole_q;
        end
      end
      M_STR:  flt.cls = ClStr;
      M_GT:   begin flt.cls = ClGt;  flt.len = 6'd1; end
      M_LT:   begin flt.cls = ClLt;  flt.len = 6'd1; end
      M_BANG: begin flt.cls = ClUnk; flt.len = 6'd1; end
      default: flt_v = 1'b0;
    endcase
  end

  always_comb begin
    dsp = mk(ClUnk, off_q, 6'd1);
    dsp_v = 1'b1;
    if (c.space || c.wstart || c.digit) dsp_v = 1'b0;
    else begin
      case (c.ch)
        8'h27, 8'h3e, 8'h3c, 8'h21: dsp_v = 1'b0;
        8'h2a: dsp.cls = ClStar;
        8'h2b: dsp.cls = ClPlus;
        8'h2d: dsp.cls = ClMinus;
        8'h2f: dsp.cls = ClSlash;
        8'h3d: dsp.cls = ClEq;
        8'h28: dsp.cls = ClLpar;
        8'h29: dsp.cls = ClRpar;
        8'h2c: dsp.cls = ClComma;
        8'h3b: dsp.cls = ClSemi;
        default: dsp.cls = ClUnk;
      endcase
    end
  end

  always_comb begin
    mode_d = mode_q; len_d = len_q; start_d = start_q; kw_d = kw_q;
    long_d = long_q; whole_d = whole_q; frac_d = frac_q; fcnt_d = fcnt_q;
    dots_d = dots_q; ntok_d = ntok_q; off_d = off_q;
    absorb = 1'b0; do_flush = 1'b0; do_disp = 1'b0; use_two = 1'b0;
    two = mk(ClGte, start_q, 6'd2); two_v = 1'b0;
    if (c.eot) begin
      do_flush = 1'b1;
      two = mk(ClEof, off_q, 6'd0); two_v = 1'b1; use_two = 1'b1;
    end else begin
      case (mode_q)
        M_WORD: absorb = c.wchar && len_q < LexFull;
        M_NUM:  absorb = (c.digit || c.ch == 8'h2e) && len_q < LexFull;
        M_STR:  absorb = c.ch != 8'h27 && len_q < LexFull;
        M_GT:   if (c.ch == 8'h3d) begin two_v = 1'b1; use_two = 1'b1; end
        M_LT: begin
          if (c.ch == 8'h3d) begin two_v = 1'b1; use_two = 1'b1; two.cls = ClLte; end
          else if (c.ch == 8'h3e) begin
            two_v = 1'b1; use_two = 1'b1; two.cls = ClNeq;
          end
        end
        M_BANG: if (c.ch == 8'h3d) begin two_v = 1'b1; use_two = 1'b1; two.cls = ClNeq; end
        default: ;
      endcase
      if (!absorb && !use_two) begin
        do_flush = 1'b1;
        do_disp  = !(mode_q == M_STR && c.ch == 8'h27);
      end
    end
    if (absorb) begin
      len_d = len_q + 6'd1;
      case (mode_q)
        M_WORD: begin
          if (len_q < 6'd7) kw_d = {kw_q[47:0], c.upper};
          else long_d = 1'b1;
        end
        M_NUM: begin
          if (c.ch == 8'h2e) begin
            if (dots_q < 2'd2) dots_d = dots_q + 2'd1;
          end else if (dots_q == 2'd0) begin
            whole_d = (mul10 > 35'(Sat31)) ? Sat31 : mul10[30:0];
          end else if (dots_q == 2'd1 && fcnt_q < 4'd9) begin
            frac_d = 30'(frac_q * 30'd10 + 30'(dig));
            fcnt_d = fcnt_q + 4'd1;
          end
        end
        default: ;
      endcase
    end
    if (use_two || do_flush) mode_d = M_IDLE;
    if (do_disp) begin
      if (c.wstart) begin
        mode_d = M_WORD; len_d = 6'd1; start_d = off_q;
        kw_d = {48'd0, c.upper}; long_d = 1'b0;
      end else if (c.digit) begin
        mode_d = M_NUM; len_d = 6'd1; start_d = off_q;
        whole_d = {27'd0, dig}; frac_d = '0; fcnt_d = '0; dots_d = '0;
      end else if (c.ch == 8'h27) begin
        mode_d = M_STR; len_d = 6'd0; start_d = off_p1;
      end else if (c.ch == 8'h3e) begin
        mode_d = M_GT; start_d = off_q;
      end else if (c.ch == 8'h3c) begin
        mode_d = M_LT; start_d = off_q;
      end else if (c.ch == 8'h21) begin
        mode_d = M_BANG; start_d = off_q;
      end
    end
    // gather candidates in order, then apply the token limit
    cand[0] = flt; cand[1] = flt; nc = 2'd0;
    if (do_flush && flt_v) begin cand[0] = flt; nc = 2'd1; end
    if ((use_two && two_v) || (do_disp && dsp_v)) begin
      if (nc == 2'd0) cand[0] = use_two ? two : dsp;
      else            cand[1] = use_two ? two : dsp;
      nc = nc + 2'd1;
    end
    if (ntok_q >= TokLimit) nk = 2'd0;
    else if (ntok_q + 9'd1 >= TokLimit && nc == 2'd2) nk = 2'd1;
    else nk = nc;
    ntok_d = ntok_q + 9'(nk);
    off_d = off_p1;
    if (c.eot) begin
      mode_d = M_IDLE; len_d = '0; start_d = '0; off_d = '0; kw_d = '0;
      long_d = 1'b0; whole_d = '0; frac_d = '0; fcnt_d = '0; dots_d = '0;
      ntok_d = '0;
    end
  end

  always_comb begin
    tok_a_o = cand[0];
    tok_b_o = cand[1];
    tok_a_o.last = nk == 2'd1;
    tok_b_o.last = 1'b1;
    tok_n_o  = nk;
    tok_we_o = go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; len_q <= '0; start_q <= '0; off_q <= '0; kw_q <= '0;
      long_q <= 1'b0; whole_q <= '0; frac_q <= '0; fcnt_q <= '0; dots_q <= '0;
      ntok_q <= '0;
    end else if (go) begin
      mode_q <= mode_d; len_q <= len_d; start_q <= start_d; off_q <= off_d;
      kw_q <= kw_d; long_q <= long_d; whole_q <= whole_d; frac_q <= frac_d;
      fcnt_q <= fcnt_d; dots_q <= dots_d; ntok_q <= ntok_d;
    end
  end
endmodule
`default_nettype wire

/* design/slx_out_fifo.sv */
// ----------------------------------------------------------------------------
// slx_out_fifo
// Result queue: takes up to two tokens a cycle, hands out one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module slx_out_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  slx_pkg::tok_t      tok_a_i,
  input  slx_pkg::tok_t      tok_b_i,
  input  wire logic [1:0]    tok_n_i,
  input  wire logic          tok_we_i,
  output logic [2:0]         space_o,
  output slx_pkg::tok_t      tok_o,
  output logic               empty_o,
  input  wire logic          pop_i
);
  import slx_pkg::*;
  tok_t       mem [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic [1:0] nw;
  logic       do_pop;

  assign nw      = tok_we_i ? tok_n_i : 2'd0;
  assign empty_o = cnt_q == 3'd0;
  assign do_pop  = pop_i && !empty_o;
  assign space_o = 3'd4 - cnt_q;
  assign tok_o   = mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + nw;
      rd_q  <= rd_q + 2'(do_pop);
      cnt_q <= cnt_q + 3'(nw) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (nw != 2'd0) mem[wr_q] <= tok_a_i;
    if (nw == 2'd2) mem[wr_q + 2'd1] <= tok_b_i;
  end
endmodule
`default_nettype wire

/* design/sql_token_lexer.sv */
// ----------------------------------------------------------------------------
// sql_token_lexer
// Streaming SQL tokenizer: characters in, token records out.
// ----------------------------------------------------------------------------
// Push one text byte per beat on the input queue (push_i/full_o), with
// end_of_text_i set on the beat that closes a statement. Tokens come out of
// the result queue (empty_o/pop_i), oldest first, one beat each.
// One character is scanned per cycle; a character may yield up to two
// tokens, which enter the result queue in the same cycle. A token caused by
// a character reaches the result ports through two registered queues: the
// push edge writes the input queue, the scanner works combinationally and
// the edge on which the scanner takes the character writes the result
// queue. Sustained rate is one character per cycle while the consumer pops
// at least as fast as tokens are produced; the scanner waits whenever the
// four-entry result queue has fewer than two free slots.
// Reset clears both queues and the scanner state; the first statement
// starts at offset zero. When the consumer stalls, the result queue fills,
// the scanner holds and the input queue raises full_o.
// ----------------------------------------------------------------------------
`default_nettype none
module sql_token_lexer (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  output logic              full_o,
  input  wire logic [7:0]   text_char_i,
  input  wire logic         end_of_text_i,
  output logic              empty_o,
  input  wire logic         pop_i,
  output logic [5:0]        token_class_o,
  output logic [30:0]       int_value_o,
  output logic [30:0]       float_whole_o,
  output logic [29:0]       float_frac_digits_o,
  output logic [3:0]        float_frac_count_o,
  output logic [15:0]       start_offset_o,
  output logic [5:0]        lexeme_length_o,
  output logic              last_of_run_o
);
  import slx_pkg::*;
  chr_t       chr;
  logic       chr_valid, chr_take, tok_we;
  tok_t       tok_a, tok_b, tok;
  logic [1:0] tok_n;
  logic [2:0] space;

  slx_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .text_char_i, .end_of_text_i,
    .chr_o(chr), .chr_valid_o(chr_valid), .chr_take_i(chr_take)
  );

  slx_back u_back (
    .clk_i, .rst_ni, .chr_i(chr), .chr_valid_i(chr_valid), .chr_take_o(chr_take),
    .tok_a_o(tok_a), .tok_b_o(tok_b), .tok_n_o(tok_n), .tok_we_o(tok_we),
    .space_i(space)
  );

  slx_out_fifo u_out (
    .clk_i, .rst_ni, .tok_a_i(tok_a), .tok_b_i(tok_b), .tok_n_i(tok_n),
    .tok_we_i(tok_we), .space_o(space), .tok_o(tok), .empty_o, .pop_i
  );

  assign token_class_o       = tok.cls;
  assign int_value_o         = tok.ival;
  assign float_whole_o       = tok.whole;
  assign float_frac_digits_o = tok.frac;
  assign float_frac_count_o  = tok.fcnt;
  assign start_offset_o      = tok.start;
  assign lexeme_length_o     = tok.len;
  assign last_of_run_o       = tok.last;
endmodule
`default_nettype wire

/* design/sql_token_lexer_chk.sv */
// ----------------------------------------------------------------------------
// sql_token_lexer_chk
// Port-level checks on the lexer's result queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sql_token_lexer_assert.svh"
module sql_token_lexer_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty_o,
  input wire logic        pop_i,
  input wire logic [5:0]  token_class_o,
  input wire logic [30:0] int_value_o,
  input wire logic [30:0] float_whole_o,
  input wire logic [5:0]  lexeme_length_o,
  input wire logic        last_of_run_o
);
  import slx_pkg::*;
  logic shown;
  assign shown = !empty_o;
  `SLX_ASSERT_IMP(a_eof_last, clk_i, rst_ni, shown && token_class_o == ClEof,
    last_of_run_o && lexeme_length_o == 6'd0)
  `SLX_ASSERT_IMP(a_ival_int, clk_i, rst_ni, shown && token_class_o != ClInt,
    int_value_o == 31'd0)
  `SLX_ASSERT_IMP(a_whole_flt, clk_i, rst_ni, shown && token_class_o != ClFloat,
    float_whole_o == 31'd0)
  `SLX_ASSERT_NXT(a_hold, clk_i, rst_ni, shown && !pop_i,
    !empty_o && $stable(token_class_o))
endmodule
bind sql_token_lexer sql_token_lexer_chk u_chk (.*);
`default_nettype wire
